// ----- rtl/core/swsfr_pkg.sv -----
// Shared types and constants for the single-wire sensor frame reader core.
// No dependencies.
`default_nettype none

package swsfr_pkg;

	localparam int unsigned ThrW   = 8;
	localparam int unsigned HoldW  = 8;
	localparam int unsigned TimerW = 15;
	localparam int unsigned HighW  = 8;
	localparam int unsigned TidxW  = 7;
	localparam int unsigned BcntW  = 6;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned FrameW = 40;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 15;

	localparam logic [BcntW-1:0] FullBits     = 6'd40;
	localparam logic [TidxW-1:0] FirstDataTr  = 7'd4;

	localparam logic [ThrW-1:0]   ThrReset   = 8'd26;
	localparam logic [HoldW-1:0]  HoldReset  = 8'd255;
	localparam logic [TimerW-1:0] LowReset   = 15'd18000;
	localparam logic [HighW-1:0]  HighReset  = 8'd40;
	localparam logic [TidxW-1:0]  LimitReset = 7'd85;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ONE_THRESHOLD    = 3'd0,
		CFG_HOLD_TIMEOUT     = 3'd1,
		CFG_START_LOW_TICKS  = 3'd2,
		CFG_START_HIGH_TICKS = 3'd3,
		CFG_TRANSITION_LIMIT = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_LOW  = 4'b0010,
		PH_HIGH = 4'b0100,
		PH_READ = 4'b1000
	} phase_t;

endpackage : swsfr_pkg

`default_nettype wire

// ----- rtl/core/single_wire_sensor_frame_reader_core.sv -----
// Single-wire sensor frame reader: start pulse generator, pulse timer,
// bit shifter and checksum check. Depends on swsfr_pkg.
`default_nettype none

// Channel   | dir | handshake          | payload
// ----------+-----+--------------------+-------------------------------------
// sample in | in  | in_valid/in_stall  | start_request, line_level
// result    | out | out_valid/out_stall| drive_*, busy_res, frame_done,
//           |     |                    | frame_ok, four data bytes, bits_received
// config    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One sample tick is one input transfer and yields exactly one result transfer.
// A transfer is taken every cycle unless stalled: the next state and the result
// are computed in one pass from the state registers and the sample, and land in
// the result register on the accepting edge. in_stall is raised only while a
// result sits in the output register and the consumer stalls it. cfg_ready is
// always high; the user must write registers only while idle, which the block
// does not check. Reset idles the controller and loads the register defaults.

module single_wire_sensor_frame_reader_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// sample channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          start_request,
	input  wire logic                          line_level,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               drive_enable,
	output logic                               drive_level,
	output logic                               busy_res,
	output logic                               frame_done,
	output logic                               frame_ok,
	output logic [swsfr_pkg::ByteW-1:0]        humidity_whole,
	output logic [swsfr_pkg::ByteW-1:0]        humidity_fraction,
	output logic [swsfr_pkg::ByteW-1:0]        temperature_whole,
	output logic [swsfr_pkg::ByteW-1:0]        temperature_fraction,
	output logic [swsfr_pkg::BcntW-1:0]        bits_received,
	// configuration channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [swsfr_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [swsfr_pkg::CfgDataW-1:0] cfg_data
);
	import swsfr_pkg::*;

	// configuration registers
	logic [ThrW-1:0]   one_threshold_q;
	logic [HoldW-1:0]  hold_timeout_q;
	logic [TimerW-1:0] start_low_q;
	logic [HighW-1:0]  start_high_q;
	logic [TidxW-1:0]  tr_limit_q;

	// frame state
	phase_t             phase_q, phase_d;
	logic [TimerW-1:0]  timer_q, timer_d;
	logic               prev_level_q, prev_level_d;
	logic [HoldW-1:0]   hold_q, hold_d;
	logic [TidxW-1:0]   tidx_q, tidx_d;
	logic [BcntW-1:0]   bcnt_q, bcnt_d;
	logic [FrameW-1:0]  frame_q, frame_d;

	// result before the output register
	logic               den_d, dlv_d, busy_d, done_d, ok_d;
	logic [ByteW-1:0]   sum_d;
	logic               finish;
	logic               accept;
	logic               take_bit;
	logic [HoldW-1:0]   hold_inc;
	logic [TidxW-1:0]   tidx_inc;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid && out_stall;
	assign accept    = in_valid && !in_stall;

	assign hold_inc = hold_q + HoldW'(1);
	assign tidx_inc = tidx_q + TidxW'(1);
	// data bits come from every even transition index from 4 on, up to forty bits
	assign take_bit = (tidx_q >= FirstDataTr) && !tidx_q[0] && (bcnt_q < FullBits);

	always_comb begin
		phase_d      = phase_q;
		timer_d      = timer_q;
		prev_level_d = prev_level_q;
		hold_d       = hold_q;
		tidx_d       = tidx_q;
		bcnt_d       = bcnt_q;
		frame_d      = frame_q;
		den_d        = 1'b0;
		dlv_d        = 1'b0;
		busy_d       = 1'b0;
		finish       = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (start_request) begin
					phase_d      = PH_LOW;
					timer_d      = TimerW'(1);
					prev_level_d = 1'b1;
					hold_d       = '0;
					tidx_d       = '0;
					bcnt_d       = '0;
					frame_d      = '0;
					den_d        = 1'b1;
					busy_d       = 1'b1;
				end
			end
			PH_LOW: begin
				busy_d = 1'b1;
				den_d  = 1'b1;
				if (timer_q >= start_low_q) begin
					phase_d = PH_HIGH;
					timer_d = TimerW'(1);
					dlv_d   = 1'b1;
				end else begin
					timer_d = timer_q + TimerW'(1);
				end
			end
			PH_HIGH: begin
				busy_d = 1'b1;
				if (timer_q >= TimerW'(start_high_q)) begin
					phase_d = PH_READ;
					timer_d = '0;
				end else begin
					timer_d = timer_q + TimerW'(1);
					den_d   = 1'b1;
					dlv_d   = 1'b1;
				end
			end
			PH_READ: begin
				busy_d = 1'b1;
				if (line_level == prev_level_q) begin
					hold_d = hold_inc;
					finish = (hold_inc >= hold_timeout_q);
				end else begin
					// level change closes the transition; the sample itself is not held time
					if (take_bit) begin
						frame_d = {frame_q[FrameW-2:0], hold_q > one_threshold_q};
						bcnt_d  = bcnt_q + BcntW'(1);
					end
					prev_level_d = line_level;
					hold_d       = '0;
					tidx_d       = tidx_inc;
					finish       = (tidx_inc >= tr_limit_q);
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// checksum over the four data bytes, 8-bit wrap
		sum_d = frame_d[39:32] + frame_d[31:24] + frame_d[23:16] + frame_d[15:8];
		done_d = finish;
		ok_d   = finish && (bcnt_d >= FullBits) && (frame_d[7:0] == sum_d);
		if (finish) begin
			phase_d = PH_IDLE;
			busy_d  = 1'b0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_threshold_q <= ThrReset;
			hold_timeout_q  <= HoldReset;
			start_low_q     <= LowReset;
			start_high_q    <= HighReset;
			tr_limit_q      <= LimitReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ONE_THRESHOLD:    one_threshold_q <= cfg_data[ThrW-1:0];
				CFG_HOLD_TIMEOUT:     hold_timeout_q  <= cfg_data[HoldW-1:0];
				CFG_START_LOW_TICKS:  start_low_q     <= cfg_data[TimerW-1:0];
				CFG_START_HIGH_TICKS: start_high_q    <= cfg_data[HighW-1:0];
				CFG_TRANSITION_LIMIT: tr_limit_q      <= cfg_data[TidxW-1:0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			timer_q      <= '0;
			prev_level_q <= 1'b1;
			hold_q       <= '0;
			tidx_q       <= '0;
			bcnt_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				timer_q      <= timer_d;
				prev_level_q <= prev_level_d;
				hold_q       <= hold_d;
				tidx_q       <= tidx_d;
				bcnt_q       <= bcnt_d;
				out_valid    <= 1'b1;
			end else if (!out_stall) begin
				out_valid    <= 1'b0;
			end
		end
	end

	// payload: frame shifter and result register, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q              <= frame_d;
			drive_enable         <= den_d;
			drive_level          <= dlv_d;
			busy_res             <= busy_d;
			frame_done           <= done_d;
			frame_ok             <= ok_d;
			humidity_whole       <= ok_d ? frame_d[39:32] : '0;
			humidity_fraction    <= ok_d ? frame_d[31:24] : '0;
			temperature_whole    <= ok_d ? frame_d[23:16] : '0;
			temperature_fraction <= ok_d ? frame_d[15:8]  : '0;
			bits_received        <= bcnt_d;
		end
	end

	// a finished frame never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !busy_res)
		else $error("done tick reports busy");

	// a good frame has all forty bits and is a done tick
	a_ok_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ok |-> frame_done && bits_received == FullBits)
		else $error("frame_ok without full done frame");

	// the line is only driven while busy
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_enable |-> busy_res)
		else $error("line driven while not busy");

	// an accepted sample always leaves a result behind
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted sample produced no result");

	// the controller is idle whenever a done tick was produced
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && done_d |=> phase_q == PH_IDLE)
		else $error("frame end did not return to idle");

endmodule : single_wire_sensor_frame_reader_core

`default_nettype wire
